/* hw/rtl/ilr_pkg.sv */
// ----------------------------------------------------------------------------
// ilr_pkg
// Shared types, widths and constants of the isometric line rasterizer.
// ----------------------------------------------------------------------------
package ilr_pkg;

    // Field widths
    localparam int COORD_W    = 10;
    localparam int H_W        = 16;
    localparam int COLOR_W    = 24;
    localparam int PIX_W      = 15;
    localparam int ZOOM_W     = 16;
    localparam int SHIFT_W    = 12;
    localparam int CFG_IDX_W  = 1;
    localparam int CFG_DATA_W = 16;

    // Fixed-point widths
    localparam int FRAC_W    = 16;
    localparam int ZOOM_FRAC = 8;
    localparam int Q_W       = 32;
    localparam int RAW_W     = 33;
    localparam int ZPROD_W   = RAW_W + ZOOM_W + 1;
    localparam int SAT_IN_W  = ZPROD_W + 1;
    localparam int DIFF_W    = Q_W + 1;
    localparam int REM_W     = Q_W + 2;
    localparam int QUO_W     = FRAC_W + 1;
    localparam int STEP_W    = QUO_W + 1;
    localparam int DIV_ITERS = QUO_W;
    localparam int DIV_CNT_W = $clog2(DIV_ITERS);

    // Defaults for the top-level parameters
    localparam int ILR_MAX_STEPS = 64;
    localparam int ILR_GRID_BITS = 10;

    // Register reset values and indexes
    localparam logic [ZOOM_W-1:0]    ZOOM_RESET  = 16'd2560;
    localparam logic [SHIFT_W-1:0]   SHIFT_RESET = 12'd300;
    localparam logic [CFG_IDX_W-1:0] REG_ZOOM    = 1'd0;
    localparam logic [CFG_IDX_W-1:0] REG_SHIFT   = 1'd1;

    // Projection constants, Q16.16
    localparam logic signed [RAW_W-1:0] K_INV_SQRT2     = 33'sd46341;
    localparam logic signed [RAW_W-1:0] K_INV_SQRT6     = 33'sd26755;
    localparam logic signed [RAW_W-1:0] K_TWO_INV_SQRT6 = 33'sd53510;

    localparam logic signed [DIFF_W-1:0] POS_ONE = 33'sd65536;
    localparam logic signed [DIFF_W-1:0] NEG_ONE = -33'sd65536;

    typedef struct packed {
        logic [COORD_W-1:0]    start_col;
        logic [COORD_W-1:0]    start_row;
        logic [COORD_W-1:0]    end_col;
        logic [COORD_W-1:0]    end_row;
        logic signed [H_W-1:0] start_height;
        logic signed [H_W-1:0] end_height;
        logic [COLOR_W-1:0]    start_color;
    } ilr_in_t;

    typedef struct packed {
        logic [PIX_W-1:0]   pixel_x;
        logic [PIX_W-1:0]   pixel_y;
        logic [COLOR_W-1:0] pixel_color;
        logic               last_pixel;
    } ilr_out_t;

    typedef struct packed {
        logic load_item;
        logic proj_raw;
        logic proj_zoom;
        logic proj_fin;
        logic proj_end;
        logic diff;
        logic mag;
        logic div_init;
        logic div_step;
        logic step_make;
        logic prep;
        logic emit;
    } ilr_cmd_t;

    typedef struct packed {
        logic degenerate;
        logic term;
    } ilr_sts_t;

    // Clamp a wide signed value to the signed 32-bit range.
    function automatic logic signed [Q_W-1:0] sat_q32(input logic signed [SAT_IN_W-1:0] v);
        logic [SAT_IN_W-Q_W:0] upper;
        upper = v[SAT_IN_W-1:Q_W-1];
        if (upper == '0 || upper == '1) begin
            return v[Q_W-1:0];
        end else if (v[SAT_IN_W-1]) begin
            return {1'b1, {(Q_W-1){1'b0}}};
        end else begin
            return {1'b0, {(Q_W-1){1'b1}}};
        end
    endfunction

    // True when |d| is below one pixel.
    function automatic logic near_q16(input logic signed [DIFF_W-1:0] d);
        return (d > NEG_ONE) && (d < POS_ONE);
    endfunction

endpackage

/* hw/rtl/isometric_line_rasterizer_unit.sv */
// Throughput: one pixel per cycle while m_ready holds; a segment yields N pixels
//   (N <= MAX_STEPS), or none. The step comes from a restoring step divider.
// Reset (aresetn low, synchronous): sequencer idle, no result pending,
//   zoom = 2560 (10.0), shift = 300.
// ----------------------------------------------------------------------------
// isometric_line_rasterizer_unit
// Projects both ends of a grid segment isometrically, then walks a Q16.16
// DDA from start to end and sends one pixel transfer per step.
// ----------------------------------------------------------------------------
module isometric_line_rasterizer_unit #(
    parameter int MAX_STEPS = ilr_pkg::ILR_MAX_STEPS,
    parameter int GRID_BITS = ilr_pkg::ILR_GRID_BITS
) (
    input  logic                            aclk,
    input  logic                            aresetn,
    // configuration writes
    input  logic                            cfg_wr_en,
    input  logic [ilr_pkg::CFG_IDX_W-1:0]   cfg_index,
    input  logic [ilr_pkg::CFG_DATA_W-1:0]  cfg_wr_data,
    // segment input
    input  logic                            s_valid,
    output logic                            s_ready,
    input  ilr_pkg::ilr_in_t                s_data,
    // pixel output
    output logic                            m_valid,
    input  logic                            m_ready,
    output ilr_pkg::ilr_out_t               m_data
);
    import ilr_pkg::*;

    // Command and status between the sequencer and the datapath
    ilr_cmd_t cmd;
    ilr_sts_t sts;

    // Sequencer: one segment at a time; take the next segment only after the
    // last pixel has been loaded into the result register.
    ilr_ctrl u_ctrl (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .s_ready (s_ready),
        .m_valid (m_valid),
        .m_ready (m_ready),
        .cmd     (cmd),
        .sts     (sts)
    );

    // Datapath: holds the registers, projects, divides and walks.
    ilr_datapath #(
        .MAX_STEPS (MAX_STEPS),
        .GRID_BITS (GRID_BITS)
    ) u_datapath (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .cfg_wr_en   (cfg_wr_en),
        .cfg_index   (cfg_index),
        .cfg_wr_data (cfg_wr_data),
        .s_data      (s_data),
        .m_data      (m_data),
        .cmd         (cmd),
        .sts         (sts)
    );

    // A taken segment closes the input in the next cycle.
    a_busy_after_transfer: assert property (@(posedge aclk) disable iff (!aresetn)
        (s_valid && s_ready) |=> !s_ready)
        else $error("input still open after a segment transfer");

    // Never overwrite a pixel that still waits for its transfer.
    a_no_overwrite: assert property (@(posedge aclk) disable iff (!aresetn)
        cmd.emit |-> (!m_valid || m_ready))
        else $error("pixel loaded over a pending result");

    // The final pixel shows up flagged and the block returns to idle.
    a_last_closes: assert property (@(posedge aclk) disable iff (!aresetn)
        (cmd.emit && sts.term) |=> (s_ready && m_valid && m_data.last_pixel))
        else $error("final pixel not flagged or sequencer not idle");

endmodule

/* hw/rtl/ilr_ctrl.sv */
// ----------------------------------------------------------------------------
// ilr_ctrl
// Sequencer: projection, setup, step division and pixel walk.
// ----------------------------------------------------------------------------
module ilr_ctrl (
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              s_valid,
    output logic              s_ready,
    output logic              m_valid,
    input  logic              m_ready,
    output ilr_pkg::ilr_cmd_t cmd,
    input  ilr_pkg::ilr_sts_t sts
);
    import ilr_pkg::*;

    typedef enum logic [13:0] {
        S_IDLE     = 14'b00000000000001,
        S_RAW_S    = 14'b00000000000010,
        S_ZOOM_S   = 14'b00000000000100,
        S_FIN_S    = 14'b00000000001000,
        S_RAW_E    = 14'b00000000010000,
        S_ZOOM_E   = 14'b00000000100000,
        S_FIN_E    = 14'b00000001000000,
        S_DIFF     = 14'b00000010000000,
        S_MAG      = 14'b00000100000000,
        S_DIV_INIT = 14'b00001000000000,
        S_DIV      = 14'b00010000000000,
        S_STEP     = 14'b00100000000000,
        S_PREP     = 14'b01000000000000,
        S_WALK     = 14'b10000000000000
    } state_t;

    state_t               state_reg, state_next;
    logic                 m_valid_reg, m_valid_next;
    logic [DIV_CNT_W-1:0] div_cnt_reg, div_cnt_next;

    always_comb begin
        state_next   = state_reg;
        m_valid_next = m_valid_reg && !m_ready;
        div_cnt_next = div_cnt_reg;
        cmd          = '0;
        case (state_reg)
            S_IDLE: begin
                if (s_valid) begin
                    cmd.load_item = 1'b1;
                    state_next    = S_RAW_S;
                end
            end
            S_RAW_S: begin
                cmd.proj_raw = 1'b1;
                state_next   = S_ZOOM_S;
            end
            S_ZOOM_S: begin
                cmd.proj_zoom = 1'b1;
                state_next    = S_FIN_S;
            end
            S_FIN_S: begin
                cmd.proj_fin = 1'b1;
                state_next   = S_RAW_E;
            end
            S_RAW_E: begin
                cmd.proj_raw = 1'b1;
                cmd.proj_end = 1'b1;
                state_next   = S_ZOOM_E;
            end
            S_ZOOM_E: begin
                cmd.proj_zoom = 1'b1;
                cmd.proj_end  = 1'b1;
                state_next    = S_FIN_E;
            end
            S_FIN_E: begin
                cmd.proj_fin = 1'b1;
                cmd.proj_end = 1'b1;
                state_next   = S_DIFF;
            end
            S_DIFF: begin
                cmd.diff   = 1'b1;
                state_next = S_MAG;
            end
            S_MAG: begin
                cmd.mag = 1'b1;
                if (sts.degenerate) begin
                    state_next = S_IDLE;
                end else begin
                    state_next = S_DIV_INIT;
                end
            end
            S_DIV_INIT: begin
                cmd.div_init = 1'b1;
                div_cnt_next = '0;
                state_next   = S_DIV;
            end
            S_DIV: begin
                cmd.div_step = 1'b1;
                if (div_cnt_reg == DIV_CNT_W'(DIV_ITERS - 1)) begin
                    state_next = S_STEP;
                end else begin
                    div_cnt_next = div_cnt_reg + 1'b1;
                end
            end
            S_STEP: begin
                cmd.step_make = 1'b1;
                state_next    = S_PREP;
            end
            S_PREP: begin
                cmd.prep   = 1'b1;
                state_next = S_WALK;
            end
            S_WALK: begin
                if (!m_valid_reg || m_ready) begin
                    cmd.emit     = 1'b1;
                    m_valid_next = 1'b1;
                    if (sts.term) begin
                        state_next = S_IDLE;
                    end
                end
            end
            default: begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= S_IDLE;
            m_valid_reg <= 1'b0;
            div_cnt_reg <= '0;
        end else begin
            state_reg   <= state_next;
            m_valid_reg <= m_valid_next;
            div_cnt_reg <= div_cnt_next;
        end
    end

    assign s_ready = (state_reg == S_IDLE);
    assign m_valid = m_valid_reg;

endmodule

/* hw/rtl/ilr_datapath.sv */
// ----------------------------------------------------------------------------
// ilr_datapath
// Projection unit, step divider, DDA walk registers and result register.
// ----------------------------------------------------------------------------
module ilr_datapath #(
    parameter int MAX_STEPS = ilr_pkg::ILR_MAX_STEPS,
    parameter int GRID_BITS = ilr_pkg::ILR_GRID_BITS
) (
    input  logic                            aclk,
    input  logic                            aresetn,
    input  logic                            cfg_wr_en,
    input  logic [ilr_pkg::CFG_IDX_W-1:0]   cfg_index,
    input  logic [ilr_pkg::CFG_DATA_W-1:0]  cfg_wr_data,
    input  ilr_pkg::ilr_in_t                s_data,
    output ilr_pkg::ilr_out_t               m_data,
    input  ilr_pkg::ilr_cmd_t               cmd,
    output ilr_pkg::ilr_sts_t               sts
);
    import ilr_pkg::*;

    localparam int GridW = (GRID_BITS < COORD_W) ? GRID_BITS : COORD_W;
    localparam int CntW  = $clog2(MAX_STEPS);

    logic [ZOOM_W-1:0]  zoom_reg;
    logic [SHIFT_W-1:0] shift_reg;

    ilr_in_t  item_reg;
    ilr_out_t out_reg;

    logic signed [RAW_W-1:0]   x_raw_reg, y_raw_reg;
    logic signed [ZPROD_W-1:0] x_zoom_reg, y_zoom_reg;
    logic signed [Q_W-1:0]     walk_x_reg, walk_y_reg;
    logic signed [Q_W-1:0]     tgt_x_reg, tgt_y_reg;
    logic signed [Q_W-1:0]     nxt_x_reg, nxt_y_reg;
    logic signed [DIFF_W-1:0]  dx_reg, dy_reg;
    logic [DIFF_W-1:0]         abs_x_reg, abs_y_reg;
    logic                      neg_x_reg, neg_y_reg;
    logic [DIFF_W-1:0]         div_m_reg;
    logic [REM_W-1:0]          rem_x_reg, rem_y_reg;
    logic [QUO_W-1:0]          quo_x_reg, quo_y_reg;
    logic signed [STEP_W-1:0]  step_x_reg, step_y_reg;
    logic [CntW-1:0]           count_reg;

    // Endpoint selection and projection terms
    logic [COORD_W-1:0]        col_g, row_g;
    logic signed [H_W-1:0]     h_sel;
    logic signed [RAW_W-1:0]   col_w, row_w, h_w;
    logic signed [ZPROD_W-1:0] zoom_w;
    logic signed [SAT_IN_W-1:0] off_w;
    logic signed [Q_W-1:0]     proj_x, proj_y;

    // Divider and walk terms
    logic                      ge_x, ge_y;
    logic [REM_W-1:0]          rem_x_after, rem_y_after;
    logic signed [STEP_W-1:0]  quo_x_s, quo_y_s;
    logic signed [Q_W-1:0]     adv_x, adv_y;
    logic                      at_target;

    always_comb begin
        if (cmd.proj_end) begin
            col_g = COORD_W'(item_reg.end_col[GridW-1:0]);
            row_g = COORD_W'(item_reg.end_row[GridW-1:0]);
            h_sel = item_reg.end_height;
        end else begin
            col_g = COORD_W'(item_reg.start_col[GridW-1:0]);
            row_g = COORD_W'(item_reg.start_row[GridW-1:0]);
            h_sel = item_reg.start_height;
        end
        col_w  = signed'(RAW_W'(col_g));
        row_w  = signed'(RAW_W'(row_g));
        h_w    = RAW_W'(h_sel);
        zoom_w = ZPROD_W'(signed'({1'b0, zoom_reg}));
        off_w  = SAT_IN_W'(signed'({1'b0, shift_reg, {FRAC_W{1'b0}}}));
        proj_x = sat_q32(SAT_IN_W'(x_zoom_reg >>> ZOOM_FRAC) + off_w);
        proj_y = sat_q32(SAT_IN_W'(y_zoom_reg >>> ZOOM_FRAC) + off_w);
    end

    always_comb begin
        ge_x        = rem_x_reg >= REM_W'(div_m_reg);
        ge_y        = rem_y_reg >= REM_W'(div_m_reg);
        rem_x_after = ge_x ? rem_x_reg - REM_W'(div_m_reg) : rem_x_reg;
        rem_y_after = ge_y ? rem_y_reg - REM_W'(div_m_reg) : rem_y_reg;
        quo_x_s     = signed'({1'b0, quo_x_reg});
        quo_y_s     = signed'({1'b0, quo_y_reg});
        adv_x       = sat_q32(SAT_IN_W'(nxt_x_reg) + SAT_IN_W'(step_x_reg));
        adv_y       = sat_q32(SAT_IN_W'(nxt_y_reg) + SAT_IN_W'(step_y_reg));
        at_target   = near_q16(DIFF_W'(nxt_x_reg) - DIFF_W'(tgt_x_reg))
                   && near_q16(DIFF_W'(nxt_y_reg) - DIFF_W'(tgt_y_reg));
    end

    // The pixel being sent is the last one when the position after it has a
    // negative coordinate, comes within a pixel of the end point or the cap is reached.
    assign sts.term = nxt_x_reg[Q_W-1] || nxt_y_reg[Q_W-1] || at_target
                   || (count_reg == CntW'(MAX_STEPS - 1));
    assign sts.degenerate = near_q16(dx_reg) && near_q16(dy_reg);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            zoom_reg  <= ZOOM_RESET;
            shift_reg <= SHIFT_RESET;
        end else if (cfg_wr_en) begin
            case (cfg_index)
                REG_ZOOM:  zoom_reg  <= cfg_wr_data[ZOOM_W-1:0];
                REG_SHIFT: shift_reg <= cfg_wr_data[SHIFT_W-1:0];
                default: begin
                end
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.load_item) begin
            item_reg <= s_data;
        end
        if (cmd.proj_raw) begin
            x_raw_reg <= (col_w - row_w) * K_INV_SQRT2;
            y_raw_reg <= (col_w + row_w) * K_INV_SQRT6 - h_w * K_TWO_INV_SQRT6;
        end
        if (cmd.proj_zoom) begin
            x_zoom_reg <= ZPROD_W'(x_raw_reg) * zoom_w;
            y_zoom_reg <= ZPROD_W'(y_raw_reg) * zoom_w;
        end
        if (cmd.proj_fin) begin
            if (cmd.proj_end) begin
                tgt_x_reg <= proj_x;
                tgt_y_reg <= proj_y;
            end else begin
                walk_x_reg <= proj_x;
                walk_y_reg <= proj_y;
            end
        end
        if (cmd.diff) begin
            dx_reg <= DIFF_W'(tgt_x_reg) - DIFF_W'(walk_x_reg);
            dy_reg <= DIFF_W'(tgt_y_reg) - DIFF_W'(walk_y_reg);
        end
        if (cmd.mag) begin
            neg_x_reg <= dx_reg[DIFF_W-1];
            neg_y_reg <= dy_reg[DIFF_W-1];
            abs_x_reg <= dx_reg[DIFF_W-1] ? DIFF_W'(-dx_reg) : DIFF_W'(dx_reg);
            abs_y_reg <= dy_reg[DIFF_W-1] ? DIFF_W'(-dy_reg) : DIFF_W'(dy_reg);
        end
        if (cmd.div_init) begin
            div_m_reg <= (abs_x_reg >= abs_y_reg) ? abs_x_reg : abs_y_reg;
            rem_x_reg <= REM_W'(abs_x_reg);
            rem_y_reg <= REM_W'(abs_y_reg);
            quo_x_reg <= '0;
            quo_y_reg <= '0;
        end
        if (cmd.div_step) begin
            rem_x_reg <= rem_x_after << 1;
            rem_y_reg <= rem_y_after << 1;
            quo_x_reg <= {quo_x_reg[QUO_W-2:0], ge_x};
            quo_y_reg <= {quo_y_reg[QUO_W-2:0], ge_y};
        end
        if (cmd.step_make) begin
            step_x_reg <= neg_x_reg ? -quo_x_s : quo_x_s;
            step_y_reg <= neg_y_reg ? -quo_y_s : quo_y_s;
        end
        if (cmd.prep) begin
            nxt_x_reg <= sat_q32(SAT_IN_W'(walk_x_reg) + SAT_IN_W'(step_x_reg));
            nxt_y_reg <= sat_q32(SAT_IN_W'(walk_y_reg) + SAT_IN_W'(step_y_reg));
            count_reg <= '0;
        end
        if (cmd.emit) begin
            out_reg.pixel_x     <= walk_x_reg[Q_W-1] ? '0 : walk_x_reg[Q_W-2:FRAC_W];
            out_reg.pixel_y     <= walk_y_reg[Q_W-1] ? '0 : walk_y_reg[Q_W-2:FRAC_W];
            out_reg.pixel_color <= item_reg.start_color;
            out_reg.last_pixel  <= sts.term;
            walk_x_reg          <= nxt_x_reg;
            walk_y_reg          <= nxt_y_reg;
            nxt_x_reg           <= adv_x;
            nxt_y_reg           <= adv_y;
            count_reg           <= count_reg + 1'b1;
        end
    end

    assign m_data = out_reg;

endmodule

/* verif/tb_isometric_line_rasterizer_unit.sv */
// ----------------------------------------------------------------------------
// tb_isometric_line_rasterizer_unit
// Self-checking bench for the isometric line rasterizer. Grid segments go in
// through a valid/ready channel. A behavioral model projects both ends, walks
// the Q16.16 DDA and queues every pixel it expects. The pixel stream is then
// checked in order against that queue. A directed table runs first, followed
// by random segments under several zoom and shift settings and under uneven
// back-pressure.
// ----------------------------------------------------------------------------
module tb_isometric_line_rasterizer_unit;
    timeunit 1ns;
    timeprecision 1ps;

    import ilr_pkg::*;

    localparam longint ONE_Q16       = 64'sd65536;
    localparam longint Q32_MAX       = 64'sd2147483647;
    localparam longint Q32_MIN       = -64'sd2147483648;
    localparam int     SEG_PIXEL_CAP = ILR_MAX_STEPS;
    // A segment with no pixel still keeps the block busy after the queue has
    // drained: settle before touching the registers.
    localparam int     SETTLE_CYCLES = 64;
    localparam int     HOLD_CYCLES   = 600;
    localparam int     REPORT_LIMIT  = 10;

    // Directed row. hand_n: -1 = use the model, 0 = no pixel, 1 = exactly one
    // pixel at (hand_x, hand_y). With hand_n = -1, hand_x >= 0 pins the first
    // pixel to (hand_x, hand_y) and the rest comes from the model.
    typedef struct packed {
        logic [COORD_W-1:0]    sc;
        logic [COORD_W-1:0]    sr;
        logic [COORD_W-1:0]    ec;
        logic [COORD_W-1:0]    er;
        logic signed [H_W-1:0] sh;
        logic signed [H_W-1:0] eh;
        logic [COLOR_W-1:0]    color;
        int                    hand_n;
        int                    hand_x;
        int                    hand_y;
    } seg_row_t;

    localparam int DIR_N = 16;
    localparam seg_row_t DIR_TAB [DIR_N] = '{
        // both ends at the grid origin: nothing to draw
        '{10'd0, 10'd0, 10'd0, 10'd0, 16'sd0, 16'sd0, 24'hFFFFFF, 0, -1, -1},
        // same point elsewhere, same height: nothing to draw
        '{10'd517, 10'd33, 10'd517, 10'd33, -16'sd77, -16'sd77, 24'h000000, 0, -1, -1},
        // the origin lands on (shift, shift)
        '{10'd0, 10'd0, 10'd1, 10'd0, 16'sd0, 16'sd0, 24'h00FF00, -1, 300, 300},
        '{10'd0, 10'd0, 10'd0, 10'd1, 16'sd0, 16'sd0, 24'h0000FF, -1, 300, 300},
        '{10'd0, 10'd0, 10'd0, 10'd0, 16'sd0, 16'sd10, 24'hFF0000, -1, 300, 300},
        '{10'd0, 10'd0, 10'd0, 10'd0, 16'sd0, -16'sd10, 24'h808080, -1, 300, 300},
        // start y saturates low: one pixel clamped to row 0, then the walk stops
        '{10'h3FF, 10'h3FF, 10'h3FF, 10'h3FF, 16'h7FFF, 16'h8000, 24'h5A5A5A, 1, 300, 0},
        // start y saturates high: clamped to the bottom row, capped walk
        '{10'h3FF, 10'h3FF, 10'd0, 10'd0, 16'h8000, 16'h7FFF, 24'hA5A5A5, -1, 300, 32767},
        '{10'h3FF, 10'd0, 10'd0, 10'h3FF, 16'sd0, 16'sd0, 24'h800001, -1, -1, -1},
        '{10'd0, 10'h3FF, 10'h3FF, 10'd0, 16'sd0, 16'sd0, 24'h7FFFFE, -1, -1, -1},
        '{10'd0, 10'd0, 10'h3FF, 10'h3FF, 16'sd0, 16'sd0, 24'h13579B, -1, -1, -1},
        '{10'h3FF, 10'h3FF, 10'd0, 10'd0, 16'sd0, 16'sd0, 24'h2468AC, -1, -1, -1},
        '{10'd10, 10'd10, 10'd11, 10'd10, 16'sd5, 16'sd9, 24'h0F0F0F, -1, -1, -1},
        '{10'd200, 10'd300, 10'd200, 10'd301, -16'sd3, 16'sd4, 24'hF0F0F0, -1, -1, -1},
        '{10'd1, 10'd1, 10'd0, 10'd0, 16'h7FFF, 16'h7FFF, 24'hC3C3C3, -1, -1, -1},
        '{10'd682, 10'd341, 10'd341, 10'd682, 16'h8000, 16'h8000, 24'h3C3C3C, -1, -1, -1}
    };

    logic                  aclk = 1'b0;
    logic                  aresetn;
    logic                  cfg_wr_en;
    logic [CFG_IDX_W-1:0]  cfg_index;
    logic [CFG_DATA_W-1:0] cfg_wr_data;
    logic                  s_valid;
    logic                  s_ready;
    ilr_in_t               s_data;
    logic                  m_valid;
    logic                  m_ready;
    ilr_out_t              m_data;

    // model copy of the registers
    longint zoom_q8;
    longint shift_px;

    ilr_out_t pixel_q [$];    // pixels still owed by the block, oldest first
    int       err_cnt;
    int       tx_idle_pct;
    int       rx_idle_pct;
    int       hold_req;       // bumped by the sequence to request a long stall
    int       hold_taken;
    int       hold_left;

    isometric_line_rasterizer_unit dut (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .cfg_wr_en   (cfg_wr_en),
        .cfg_index   (cfg_index),
        .cfg_wr_data (cfg_wr_data),
        .s_valid     (s_valid),
        .s_ready     (s_ready),
        .s_data      (s_data),
        .m_valid     (m_valid),
        .m_ready     (m_ready),
        .m_data      (m_data)
    );

    always #6 aclk = ~aclk;

    // ------------------------------------------------------------------------
    // Pixel model
    // ------------------------------------------------------------------------
    function automatic longint clamp_q32(input longint v);
        if (v > Q32_MAX) return Q32_MAX;
        if (v < Q32_MIN) return Q32_MIN;
        return v;
    endfunction

    function automatic longint mag_q(input longint v);
        return (v < 0) ? -v : v;
    endfunction

    // Truncate a Q16.16 position to a screen coordinate, clamped to 15 bits.
    function automatic logic [PIX_W-1:0] screen_coord(input longint v);
        longint whole;
        if (v < 0) return '0;
        whole = v / ONE_Q16;
        if (whole > 32767) return {PIX_W{1'b1}};
        return whole[PIX_W-1:0];
    endfunction

    // Isometric projection, zoom (floor of Q8.8 product) and shift.
    function automatic void project_point(input longint col, input longint row,
                                          input longint h, output longint px,
                                          output longint py);
        longint ux;
        longint uy;
        longint offs;
        ux   = (col - row) * longint'(K_INV_SQRT2);
        uy   = (col + row) * longint'(K_INV_SQRT6) - h * longint'(K_TWO_INV_SQRT6);
        offs = shift_px * ONE_Q16;
        px   = clamp_q32(((ux * zoom_q8) >>> ZOOM_FRAC) + offs);
        py   = clamp_q32(((uy * zoom_q8) >>> ZOOM_FRAC) + offs);
    endfunction

    // Walk one segment and queue its pixels; return how many were queued.
    function automatic int rasterize_segment(input ilr_in_t seg);
        longint   wx;
        longint   wy;
        longint   tx;
        longint   ty;
        longint   dx;
        longint   dy;
        longint   span;
        longint   sx;
        longint   sy;
        int       n;
        bit       stop;
        ilr_out_t px;
        project_point(longint'(seg.start_col), longint'(seg.start_row),
                      longint'($signed(seg.start_height)), wx, wy);
        project_point(longint'(seg.end_col), longint'(seg.end_row),
                      longint'($signed(seg.end_height)), tx, ty);
        if (mag_q(tx - wx) < ONE_Q16 && mag_q(ty - wy) < ONE_Q16) return 0;
        dx   = tx - wx;
        dy   = ty - wy;
        span = (mag_q(dx) > mag_q(dy)) ? mag_q(dx) : mag_q(dy);
        if (span == 0) return 0;
        sx = (dx * ONE_Q16) / span;
        sy = (dy * ONE_Q16) / span;
        n  = 0;
        forever begin
            px.pixel_x     = screen_coord(wx);
            px.pixel_y     = screen_coord(wy);
            px.pixel_color = seg.start_color;
            n++;
            wx   = clamp_q32(wx + sx);
            wy   = clamp_q32(wy + sy);
            stop = (wx < 0) || (wy < 0) || n >= SEG_PIXEL_CAP ||
                   (mag_q(tx - wx) < ONE_Q16 && mag_q(ty - wy) < ONE_Q16);
            px.last_pixel = stop;
            pixel_q.push_back(px);
            if (stop) break;
        end
        return n;
    endfunction

    // ------------------------------------------------------------------------
    // Random segments
    // ------------------------------------------------------------------------
    function automatic logic [COORD_W-1:0] pick_coord();
        case ($urandom_range(2))
            0: return '0;
            1: return '1;
            default: return COORD_W'($urandom);
        endcase
    endfunction

    function automatic logic signed [H_W-1:0] pick_height();
        case ($urandom_range(4))
            0: return 16'h8000;
            1: return 16'h7FFF;
            2: return 16'sd0;
            3: return H_W'(int'($urandom_range(40)) - 20);
            default: return H_W'($urandom);
        endcase
    endfunction

    // Mostly neighbor segments as a mesh traversal makes them, with mild
    // height changes; the rest fully random or built from extremes.
    function automatic ilr_in_t random_segment();
        ilr_in_t seg;
        int      kind;
        kind = $urandom_range(99);
        seg.start_color = COLOR_W'($urandom);
        if (kind < 55) begin
            seg.start_col = COORD_W'($urandom);
            seg.start_row = COORD_W'($urandom);
            seg.end_col   = seg.start_col;
            seg.end_row   = seg.start_row;
            if ($urandom_range(1)) begin
                seg.end_col = seg.start_col + ($urandom_range(1) ? 10'd1 : 10'h3FF);
            end else begin
                seg.end_row = seg.start_row + ($urandom_range(1) ? 10'd1 : 10'h3FF);
            end
            seg.start_height = H_W'(int'($urandom_range(60)) - 30);
            seg.end_height   = H_W'(int'($urandom_range(60)) - 30);
        end else if (kind < 80) begin
            seg.start_col    = COORD_W'($urandom);
            seg.start_row    = COORD_W'($urandom);
            seg.end_col      = COORD_W'($urandom);
            seg.end_row      = COORD_W'($urandom);
            seg.start_height = H_W'($urandom);
            seg.end_height   = H_W'($urandom);
        end else begin
            seg.start_col    = pick_coord();
            seg.start_row    = pick_coord();
            seg.end_col      = pick_coord();
            seg.end_row      = pick_coord();
            seg.start_height = pick_height();
            seg.end_height   = pick_height();
        end
        return seg;
    endfunction

    // ------------------------------------------------------------------------
    // Sender side
    // ------------------------------------------------------------------------
    // Entered and left at a falling edge. Idle for a random number of cycles,
    // then hold the segment until its transfer and queue what it owes.
    task automatic send_segment(input ilr_in_t seg, input int hand_n,
                                input int hand_x, input int hand_y);
        int       n;
        ilr_out_t px;
        while ($urandom_range(99) < tx_idle_pct) begin
            s_valid <= 1'b0;
            @(negedge aclk);
        end
        s_valid <= 1'b1;
        s_data  <= seg;
        do @(posedge aclk); while (!s_ready);
        if (hand_n == 1) begin
            px.pixel_x     = PIX_W'(hand_x);
            px.pixel_y     = PIX_W'(hand_y);
            px.pixel_color = seg.start_color;
            px.last_pixel  = 1'b1;
            pixel_q.push_back(px);
        end else if (hand_n != 0) begin
            n = rasterize_segment(seg);
            if (hand_x >= 0 && n > 0) begin
                px         = pixel_q[pixel_q.size() - n];
                px.pixel_x = PIX_W'(hand_x);
                px.pixel_y = PIX_W'(hand_y);
                pixel_q[pixel_q.size() - n] = px;
            end
        end
        @(negedge aclk);
    endtask

    // Drop valid, wait for every owed pixel, then let the block settle.
    task automatic drain_block();
        s_valid <= 1'b0;
        while (pixel_q.size() != 0) @(negedge aclk);
        repeat (SETTLE_CYCLES) @(negedge aclk);
    endtask

    // Write both registers back to back; only called with the block idle.
    task automatic set_config(input int zoom_val, input int shift_val);
        cfg_wr_en   <= 1'b1;
        cfg_index   <= REG_ZOOM;
        cfg_wr_data <= CFG_DATA_W'(zoom_val);
        zoom_q8     = longint'(zoom_val & 16'hFFFF);
        @(negedge aclk);
        cfg_index   <= REG_SHIFT;
        cfg_wr_data <= CFG_DATA_W'(shift_val);
        shift_px    = longint'(shift_val & 12'hFFF);
        @(negedge aclk);
        cfg_wr_en   <= 1'b0;
        @(negedge aclk);
    endtask

    task automatic flag_error(input string msg);
        if (err_cnt < REPORT_LIMIT) $display("%s", msg);
        err_cnt++;
    endtask

    // ------------------------------------------------------------------------
    // Receiver side: random ready, plus one long hold on request so the block
    // fills up and pushes back on the sender.
    // ------------------------------------------------------------------------
    always @(negedge aclk) begin
        if (hold_left > 0) begin
            m_ready   <= 1'b0;
            hold_left = hold_left - 1;
        end else if (hold_req != hold_taken) begin
            hold_taken = hold_req;
            hold_left  = HOLD_CYCLES;
            m_ready   <= 1'b0;
        end else begin
            m_ready <= ($urandom_range(99) >= rx_idle_pct);
        end
    end

    // ------------------------------------------------------------------------
    // Pixel checker: every transfer must match the oldest owed pixel.
    // ------------------------------------------------------------------------
    always @(posedge aclk) begin
        ilr_out_t want;
        if (aresetn && m_valid && m_ready) begin
            if (pixel_q.size() == 0) begin
                flag_error($sformatf("unexpected pixel x=%0d y=%0d color=%06h last=%0b",
                                     m_data.pixel_x, m_data.pixel_y,
                                     m_data.pixel_color, m_data.last_pixel));
            end else begin
                want = pixel_q.pop_front();
                if (m_data.pixel_x !== want.pixel_x || m_data.pixel_y !== want.pixel_y ||
                    m_data.pixel_color !== want.pixel_color ||
                    m_data.last_pixel !== want.last_pixel) begin
                    flag_error($sformatf(
                        "pixel mismatch: exp x=%0d y=%0d color=%06h last=%0b, %s",
                        want.pixel_x, want.pixel_y, want.pixel_color, want.last_pixel,
                        $sformatf("got x=%0d y=%0d color=%06h last=%0b",
                                  m_data.pixel_x, m_data.pixel_y, m_data.pixel_color,
                                  m_data.last_pixel)));
                end
            end
        end
    end

    // ------------------------------------------------------------------------
    // Sequence
    // ------------------------------------------------------------------------
    initial begin
        // phase settings: zoom and shift extremes, a random pair, a mid pair, back to the reset pair
        int      ph_zoom  [7];
        int      ph_shift [7];
        int      ph_items [7];
        ilr_in_t seg;
        ph_zoom  = '{256, 65535, 0, 1, 0, 768, 2560};
        ph_shift = '{0, 4095, 4095, 0, 0, 2048, 300};
        ph_items = '{90, 80, 20, 40, 90, 90, 90};
        ph_zoom[4]  = $urandom_range(65535);
        ph_shift[4] = $urandom_range(4095);

        aresetn     = 1'b0;
        cfg_wr_en   = 1'b0;
        cfg_index   = '0;
        cfg_wr_data = '0;
        s_valid     = 1'b0;
        s_data      = '0;
        m_ready     = 1'b0;
        err_cnt     = 0;
        hold_req    = 0;
        hold_taken  = 0;
        hold_left   = 0;
        zoom_q8     = longint'(ZOOM_RESET);
        shift_px    = longint'(SHIFT_RESET);
        // sender rarely idle, receiver mostly stalled
        tx_idle_pct = 6;
        rx_idle_pct = 74;

        repeat (7) @(negedge aclk);
        aresetn <= 1'b1;
        @(negedge aclk);

        // directed rows under the reset register values
        for (int i = 0; i < DIR_N; i++) begin
            seg.start_col    = DIR_TAB[i].sc;
            seg.start_row    = DIR_TAB[i].sr;
            seg.end_col      = DIR_TAB[i].ec;
            seg.end_row      = DIR_TAB[i].er;
            seg.start_height = DIR_TAB[i].sh;
            seg.end_height   = DIR_TAB[i].eh;
            seg.start_color  = DIR_TAB[i].color;
            send_segment(seg, DIR_TAB[i].hand_n, DIR_TAB[i].hand_x, DIR_TAB[i].hand_y);
        end
        drain_block();

        for (int p = 0; p < 7; p++) begin
            if (p == 2) begin
                // swap: sender mostly idle, receiver rarely stalls
                tx_idle_pct = 74;
                rx_idle_pct = 6;
            end else if (p == 5) begin
                tx_idle_pct = 0;
                rx_idle_pct = 0;
            end
            set_config(ph_zoom[p], ph_shift[p]);
            // long receiver stall while segments keep coming
            if (p == 0) hold_req++;
            for (int k = 0; k < ph_items[p]; k++) begin
                send_segment(random_segment(), -1, -1, -1);
            end
            drain_block();
        end

        if (pixel_q.size() != 0) begin
            flag_error($sformatf("%0d pixels never arrived", pixel_q.size()));
        end
        if (err_cnt == 0) begin
            $display("tb_isometric_line_rasterizer_unit: done, clean");
        end else begin
            $display("tb_isometric_line_rasterizer_unit: done, errors");
        end
        $finish;
    end

    // watchdog
    initial begin
        #(40_000_000);
        $display("tb_isometric_line_rasterizer_unit: done, errors");
        $finish;
    end

endmodule
